FILE: src/grsr_pkg.sv
// Shared constants, codes and types for the grid spring relaxation unit.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package grsr_pkg;

    // Field widths of the stream words.
    localparam int COORD_W    = 32;
    localparam int REST_W     = 32;
    localparam int NB_COUNT   = 8;
    localparam int IN_DATA_W  = 2 * COORD_W + NB_COUNT * REST_W;
    localparam int OUT_DATA_W = 2 * COORD_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 11;
    localparam int DAMP_W     = 16;
    localparam int DAMP_BITS  = 16;
    localparam int STEP_W     = 31;
    localparam int QUEUE_DEPTH = 4;

    // Item kinds carried in tuser.
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd3;

    // Reset values of the registers.
    localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd3277;
    localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 31'd65536;
    localparam int GRID_SIZE_RST = 1024;
    localparam int GRID_SIZE_MIN = 3;

    // Neighbour offsets along one axis.
    localparam logic [1:0] DIR_MINUS = 2'd0;
    localparam logic [1:0] DIR_ZERO  = 2'd1;
    localparam logic [1:0] DIR_PLUS  = 2'd2;

    // Neighbour order: up-left, up, down-left, down, up-right, down-right, left, right.
    localparam logic [1:0] NB_DX [NB_COUNT] = '{DIR_MINUS, DIR_ZERO, DIR_MINUS, DIR_ZERO,
                                                DIR_PLUS, DIR_PLUS, DIR_MINUS, DIR_PLUS};
    localparam logic [1:0] NB_DY [NB_COUNT] = '{DIR_MINUS, DIR_MINUS, DIR_PLUS, DIR_PLUS,
                                                DIR_MINUS, DIR_PLUS, DIR_ZERO, DIR_ZERO};

    typedef logic signed [COORD_W-1:0] coord_t;

    // Tuning values handed from the register bank to the arithmetic back end.
    typedef struct packed {
        logic [DAMP_W-1:0] damping;
        logic [STEP_W-1:0] step_limit;
    } tune_t;

    // Magnitude of a signed coordinate difference.
    function automatic logic [COORD_W-1:0] mag32(input coord_t x);
        logic [COORD_W:0] t;
        begin
            t = x[COORD_W-1] ? -{x[COORD_W-1], x} : {1'b0, x};
            return t[COORD_W-1:0];
        end
    endfunction

    // Saturate a 33-bit signed value into 32 bits.
    function automatic coord_t sat33(input logic signed [COORD_W:0] x);
        begin
            if (x[COORD_W] != x[COORD_W-1])
                return x[COORD_W] ? coord_t'({1'b1, {(COORD_W-1){1'b0}}})
                                  : coord_t'({1'b0, {(COORD_W-1){1'b1}}});
            return x[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/grsr_line_store.sv
// Line stores holding the recent points' coordinates and rest lengths.
// Uses grsr_pkg for word widths; one write port and one read port per memory.
`timescale 1ns / 1ps
`default_nettype none

module grsr_line_store #(
    parameter int AW = 12
) (
    input  wire logic                                          clk,
    input  wire logic                                          wr_en,
    input  wire logic [AW-1:0]                                 wr_addr,
    input  wire logic [2*grsr_pkg::COORD_W-1:0]                wr_coord,
    input  wire logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] wr_rest,
    input  wire logic                                          coord_rd_en,
    input  wire logic [AW-1:0]                                 coord_rd_addr,
    output logic      [2*grsr_pkg::COORD_W-1:0]                coord_rd_data,
    input  wire logic                                          rest_rd_en,
    input  wire logic [AW-1:0]                                 rest_rd_addr,
    output logic      [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] rest_rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [2*grsr_pkg::COORD_W-1:0]                 coord_mem [DEPTH];
    logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] rest_mem  [DEPTH];
    logic [2*grsr_pkg::COORD_W-1:0]                 coord_rd_reg;
    logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] rest_rd_reg;

    // Coordinate memory, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coord_mem[wr_addr] <= wr_coord;
        end
        if (coord_rd_en)
        begin
            coord_rd_reg <= coord_mem[coord_rd_addr];
        end
    end

    // Rest length memory, one row of eight lengths per point.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rest_mem[wr_addr] <= wr_rest;
        end
        if (rest_rd_en)
        begin
            rest_rd_reg <= rest_mem[rest_rd_addr];
        end
    end

    assign coord_rd_data = coord_rd_reg;
    assign rest_rd_data  = rest_rd_reg;

endmodule

`default_nettype wire

FILE: src/grsr_fifo.sv
// Short job queue between the front end and the arithmetic back end.
// Uses grsr_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module grsr_fifo #(
    parameter int W = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic      [W-1:0] pop_data
);

    localparam int DEPTH = grsr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    // Pointer and fill count update.
    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && not_empty;
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: src/grsr_front.sv
// Front end: accepts words, stores points in the line stores and queues jobs.
// Uses grsr_pkg for item kinds and field widths.
`timescale 1ns / 1ps
`default_nettype none

module grsr_front #(
    parameter int GW = 11,
    parameter int NW = 21,
    parameter int XW = 10,
    parameter int YW = 10,
    parameter int AW = 12,
    parameter int JW = 33
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire logic                                          s_op,
    input  wire logic [2*grsr_pkg::COORD_W-1:0]                s_coords,
    input  wire logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] s_rests,
    input  wire logic                                          restart,
    input  wire logic [GW-1:0]                                 grid_w,
    input  wire logic [NW-1:0]                                 total,
    output logic                                               wr_en,
    output logic      [AW-1:0]                                 wr_addr,
    output logic      [2*grsr_pkg::COORD_W-1:0]                wr_coord,
    output logic      [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] wr_rest,
    output logic                                               job_push,
    output logic      [JW-1:0]                                 job_data,
    input  wire logic                                          job_full
);

    localparam int SW = (NW > AW) ? NW : AW;

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] op_reg, op_next;
    logic          done_reg, done_next;
    logic [XW-1:0] ox_reg, ox_next;
    logic [YW-1:0] oy_reg, oy_next;
    logic [SW-1:0] n_ext, op_ext;
    logic          take, is_point, is_flush, emit, last;

    // Classify the word and advance the input and output positions.
    always_comb
    begin
        take     = s_valid && s_ready;
        n_ext    = SW'(n_reg);
        op_ext   = SW'(op_reg);
        is_point = take && (s_op == grsr_pkg::OP_POINT) && !done_reg;
        is_flush = take && (s_op == grsr_pkg::OP_FLUSH) && done_reg && (op_reg < total);
        emit     = (is_point && (n_reg >= (NW'(grid_w) + NW'(1)))) || is_flush;
        last     = is_flush && ((op_reg + NW'(1)) == total);
        n_next    = n_reg;
        op_next   = op_reg;
        done_next = done_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        if (is_point)
        begin
            n_next = n_reg + NW'(1);
            if ((n_reg + NW'(1)) == total)
            begin
                done_next = 1'b1;
            end
        end
        if (emit)
        begin
            op_next = op_reg + NW'(1);
            if ((GW'(ox_reg) + GW'(1)) == grid_w)
            begin
                ox_next = '0;
                oy_next = oy_reg + YW'(1);
            end
            else
            begin
                ox_next = ox_reg + XW'(1);
            end
        end
        if (last || restart)
        begin
            n_next    = '0;
            op_next   = '0;
            done_next = 1'b0;
            ox_next   = '0;
            oy_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            op_reg   <= '0;
            done_reg <= 1'b0;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end
        else
        begin
            n_reg    <= n_next;
            op_reg   <= op_next;
            done_reg <= done_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
        end
    end

    // A word is taken only while the queue has room for the job it may cause.
    assign s_ready  = !job_full;
    assign wr_en    = is_point;
    assign wr_addr  = n_ext[AW-1:0];
    assign wr_coord = s_coords;
    assign wr_rest  = s_rests;
    assign job_push = emit;
    assign job_data = {op_ext[AW-1:0], ox_reg, oy_reg, last};

endmodule

`default_nettype wire

FILE: src/grsr_back.sv
// Back end: per job reads the 3x3 window, runs square root, multiply and divide
// units neighbour by neighbour, then damps, clamps and registers the result.
// Uses grsr_pkg for neighbour tables, widths and helper functions.
`timescale 1ns / 1ps
`default_nettype none

module grsr_back #(
    parameter int GW = 11,
    parameter int GH = 11,
    parameter int XW = 10,
    parameter int YW = 10,
    parameter int AW = 12,
    parameter int JW = 33
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          job_valid,
    output logic                                               job_pop,
    input  wire logic [JW-1:0]                                 job_data,
    input  wire logic [GW-1:0]                                 grid_w,
    input  wire logic [GH-1:0]                                 grid_h,
    input  wire grsr_pkg::tune_t                               tune,
    output logic                                               coord_rd_en,
    output logic      [AW-1:0]                                 coord_rd_addr,
    input  wire logic [2*grsr_pkg::COORD_W-1:0]                coord_rd_data,
    output logic                                               rest_rd_en,
    output logic      [AW-1:0]                                 rest_rd_addr,
    input  wire logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] rest_rd_data,
    output logic                                               m_valid,
    input  wire logic                                          m_ready,
    output logic      [grsr_pkg::OUT_DATA_W-1:0]               m_data,
    output logic                                               m_last
);

    localparam int CWD = grsr_pkg::COORD_W;
    localparam int VW  = 40;
    localparam int PW  = VW + grsr_pkg::DAMP_W;
    localparam int STEP_W_L = grsr_pkg::STEP_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CEN  = 4'd1;
    localparam logic [3:0] ST_SEL  = 4'd2;
    localparam logic [3:0] ST_NCAP = 4'd3;
    localparam logic [3:0] ST_SQR  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_ROOT = 4'd6;
    localparam logic [3:0] ST_FAC  = 4'd7;
    localparam logic [3:0] ST_MUL  = 4'd8;
    localparam logic [3:0] ST_DADD = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;
    localparam logic [3:0] ST_ACC  = 4'd11;
    localparam logic [3:0] ST_DAMP = 4'd12;
    localparam logic [3:0] ST_RND  = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    localparam logic [6:0] ROOT_LAST = 7'd31;
    localparam logic [6:0] DIV_LAST  = 7'd64;

    // Control registers.
    logic [3:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    // Job and datapath registers.
    logic [AW-1:0]                                 slot_reg;
    logic [XW-1:0]                                 px_reg;
    logic [YW-1:0]                                 py_reg;
    logic                                          last_reg;
    grsr_pkg::coord_t                              cu_reg, cv_reg, du_reg, dv_reg;
    logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] rest_reg;
    logic [2*CWD-1:0]                              sqa_reg, sqb_reg, sq_reg;
    logic [CWD+1:0]                                srem_reg;
    logic [CWD-1:0]                                root_reg;
    logic signed [CWD:0]                           fac_reg;
    logic [2*CWD:0]                                mu_reg, mv_reg, dqu_reg, dqv_reg;
    logic [CWD-1:0]                                dru_reg, drv_reg;
    logic signed [VW-1:0]                          vu_reg, vv_reg;
    logic [PW-1:0]                                 pu_reg, pv_reg;
    grsr_pkg::coord_t                              out_u_reg, out_v_reg;
    logic                                          out_last_reg;
    grsr_pkg::coord_t                              nu_reg, nv_reg;

    // Combinational helpers.
    logic [1:0]             dx, dy;
    logic                   in_grid, last_nb;
    logic [AW-1:0]          nb_addr, row_off;
    logic [grsr_pkg::REST_W-1:0] rest_i;
    grsr_pkg::coord_t       nb_u, nb_v, du_sat, dv_sat;
    logic [CWD-1:0]         au, av;
    logic [CWD:0]           af;
    logic [CWD+3:0]         r2, rt;
    logic [CWD:0]           ru2, rv2;
    logic                   qu_bit, qv_bit;
    logic [CWD+1:0]         qu, qv;
    logic                   term_neg;
    logic [VW-1:0]          mag_u, mag_v;
    logic [PW:0]            rnd_u, rnd_v;
    logic [STEP_W_L-1:0]    lim_u, lim_v;
    logic signed [CWD:0]    off_u, off_v;

    // Neighbour selection and address.
    always_comb
    begin
        dx      = grsr_pkg::NB_DX[idx_reg];
        dy      = grsr_pkg::NB_DY[idx_reg];
        in_grid = !((dx == grsr_pkg::DIR_MINUS) && (px_reg == '0))
               && !((dx == grsr_pkg::DIR_PLUS) && ((GW'(px_reg) + GW'(1)) >= grid_w))
               && !((dy == grsr_pkg::DIR_MINUS) && (py_reg == '0))
               && !((dy == grsr_pkg::DIR_PLUS) && ((GH'(py_reg) + GH'(1)) >= grid_h));
        last_nb = (idx_reg == 3'd7);
        case (dy)
            grsr_pkg::DIR_MINUS: row_off = -AW'(grid_w);
            grsr_pkg::DIR_PLUS:  row_off = AW'(grid_w);
            default:             row_off = '0;
        endcase
        case (dx)
            grsr_pkg::DIR_MINUS: nb_addr = slot_reg + row_off - AW'(1);
            grsr_pkg::DIR_PLUS:  nb_addr = slot_reg + row_off + AW'(1);
            default:             nb_addr = slot_reg + row_off;
        endcase
        rest_i = rest_reg[idx_reg*grsr_pkg::REST_W +: grsr_pkg::REST_W];
    end

    // Differences, magnitudes and one step each of the root and divide units.
    always_comb
    begin
        nb_u   = coord_rd_data[CWD-1:0];
        nb_v   = coord_rd_data[2*CWD-1:CWD];
        du_sat = grsr_pkg::sat33({nb_u[CWD-1], nb_u} - {cu_reg[CWD-1], cu_reg});
        dv_sat = grsr_pkg::sat33({nb_v[CWD-1], nb_v} - {cv_reg[CWD-1], cv_reg});
        au     = grsr_pkg::mag32(du_reg);
        av     = grsr_pkg::mag32(dv_reg);
        af     = fac_reg[CWD] ? (CWD+1)'(-fac_reg) : (CWD+1)'(fac_reg);
        r2     = {srem_reg, sq_reg[2*CWD-1:2*CWD-2]};
        rt     = {2'b00, root_reg, 2'b01};
        ru2    = {dru_reg, dqu_reg[2*CWD]};
        rv2    = {drv_reg, dqv_reg[2*CWD]};
        qu_bit = (ru2 >= {1'b0, root_reg});
        qv_bit = (rv2 >= {1'b0, root_reg});
        qu     = dqu_reg[CWD+1:0];
        qv     = dqv_reg[CWD+1:0];
        term_neg = fac_reg[CWD];
        mag_u  = vu_reg[VW-1] ? VW'(-vu_reg) : VW'(vu_reg);
        mag_v  = vv_reg[VW-1] ? VW'(-vv_reg) : VW'(vv_reg);
        rnd_u  = (PW+1)'(pu_reg) + (PW+1)'(1 << (grsr_pkg::DAMP_BITS - 1));
        rnd_v  = (PW+1)'(pv_reg) + (PW+1)'(1 << (grsr_pkg::DAMP_BITS - 1));
        if (rnd_u[PW:grsr_pkg::DAMP_BITS] > (PW+1-grsr_pkg::DAMP_BITS)'(tune.step_limit))
            lim_u = tune.step_limit;
        else
            lim_u = rnd_u[grsr_pkg::DAMP_BITS +: STEP_W_L];
        if (rnd_v[PW:grsr_pkg::DAMP_BITS] > (PW+1-grsr_pkg::DAMP_BITS)'(tune.step_limit))
            lim_v = tune.step_limit;
        else
            lim_v = rnd_v[grsr_pkg::DAMP_BITS +: STEP_W_L];
        off_u = vu_reg[VW-1] ? -(CWD+1)'(lim_u) : (CWD+1)'(lim_u);
        off_v = vv_reg[VW-1] ? -(CWD+1)'(lim_v) : (CWD+1)'(lim_v);
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        job_pop       = 1'b0;
        coord_rd_en   = 1'b0;
        coord_rd_addr = nb_addr;
        rest_rd_en    = 1'b0;
        rest_rd_addr  = job_data[JW-1 -: AW];
        if (m_valid_reg && m_ready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop       = 1'b1;
                    coord_rd_en   = 1'b1;
                    coord_rd_addr = job_data[JW-1 -: AW];
                    rest_rd_en    = 1'b1;
                    state_next    = ST_CEN;
                end
            end
            ST_CEN:
            begin
                idx_next   = '0;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (in_grid)
                begin
                    coord_rd_en = 1'b1;
                    state_next  = ST_NCAP;
                end
                else if (last_nb)
                begin
                    state_next = ST_DAMP;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            ST_NCAP: state_next = ST_SQR;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:
            begin
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_FAC;
                end
            end
            ST_FAC:
            begin
                if (root_reg != '0)
                begin
                    state_next = ST_MUL;
                end
                else if (last_nb)
                begin
                    state_next = ST_DAMP;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_SEL;
                end
            end
            ST_MUL: state_next = ST_DADD;
            ST_DADD:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (last_nb)
                begin
                    state_next = ST_DAMP;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_SEL;
                end
            end
            ST_DAMP: state_next = ST_RND;
            ST_RND:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers, loaded by state.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                slot_reg <= job_data[JW-1 -: AW];
                px_reg   <= job_data[YW+XW:YW+1];
                py_reg   <= job_data[YW:1];
                last_reg <= job_data[0];
            end
            ST_CEN:
            begin
                cu_reg   <= coord_rd_data[CWD-1:0];
                cv_reg   <= coord_rd_data[2*CWD-1:CWD];
                rest_reg <= rest_rd_data;
                vu_reg   <= '0;
                vv_reg   <= '0;
            end
            ST_NCAP:
            begin
                du_reg <= du_sat;
                dv_reg <= dv_sat;
            end
            ST_SQR:
            begin
                sqa_reg <= {{CWD{1'b0}}, au} * {{CWD{1'b0}}, au};
                sqb_reg <= {{CWD{1'b0}}, av} * {{CWD{1'b0}}, av};
            end
            ST_SUM:
            begin
                sq_reg   <= sqa_reg + sqb_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_ROOT:
            begin
                sq_reg <= {sq_reg[2*CWD-3:0], 2'b00};
                if (r2 >= rt)
                begin
                    srem_reg <= (CWD+2)'(r2 - rt);
                    root_reg <= {root_reg[CWD-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= r2[CWD+1:0];
                    root_reg <= {root_reg[CWD-2:0], 1'b0};
                end
            end
            ST_FAC:
            begin
                fac_reg <= $signed({1'b0, root_reg}) - $signed({1'b0, rest_i});
            end
            ST_MUL:
            begin
                mu_reg <= {{(CWD+1){1'b0}}, au} * {{CWD{1'b0}}, af};
                mv_reg <= {{(CWD+1){1'b0}}, av} * {{CWD{1'b0}}, af};
            end
            ST_DADD:
            begin
                dqu_reg <= mu_reg + (2*CWD+1)'(root_reg >> 1);
                dqv_reg <= mv_reg + (2*CWD+1)'(root_reg >> 1);
                dru_reg <= '0;
                drv_reg <= '0;
            end
            ST_DIV:
            begin
                dqu_reg <= {dqu_reg[2*CWD-1:0], qu_bit};
                dqv_reg <= {dqv_reg[2*CWD-1:0], qv_bit};
                dru_reg <= qu_bit ? CWD'(ru2 - {1'b0, root_reg}) : ru2[CWD-1:0];
                drv_reg <= qv_bit ? CWD'(rv2 - {1'b0, root_reg}) : rv2[CWD-1:0];
            end
            ST_ACC:
            begin
                vu_reg <= ((du_reg[CWD-1] ^ term_neg) ? vu_reg - VW'(qu) : vu_reg + VW'(qu));
                vv_reg <= ((dv_reg[CWD-1] ^ term_neg) ? vv_reg - VW'(qv) : vv_reg + VW'(qv));
            end
            ST_DAMP:
            begin
                pu_reg <= PW'(mag_u) * PW'(tune.damping);
                pv_reg <= PW'(mag_v) * PW'(tune.damping);
            end
            ST_RND:
            begin
                // Only axes on which the point is interior move.
                if ((px_reg != '0) && ((GW'(px_reg) + GW'(1)) < grid_w))
                    nu_reg <= grsr_pkg::sat33({cu_reg[CWD-1], cu_reg} + off_u);
                else
                    nu_reg <= cu_reg;
                if ((py_reg != '0) && ((GH'(py_reg) + GH'(1)) < grid_h))
                    nv_reg <= grsr_pkg::sat33({cv_reg[CWD-1], cv_reg} + off_v);
                else
                    nv_reg <= cv_reg;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    out_u_reg    <= nu_reg;
                    out_v_reg    <= nv_reg;
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = {out_v_reg, out_u_reg};
    assign m_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: src/grid_spring_relaxation_step_unit.sv
// Top level of the grid spring relaxation unit: register bank, front end,
// job queue, line stores and arithmetic back end. Depends on grsr_pkg and all grsr_ modules.
//
//  channel   direction  signals                       word
//  s_        in         s_tvalid s_tready s_tdata     one point or flush tick (kind in s_tuser)
//  m_        out        m_tvalid m_tready m_tdata     relaxed point, m_tlast on the final one
//  cfg_      in         cfg_valid cfg_ready           register write, index and data
//
// A point with all eight neighbours in the grid runs, in the back end, per neighbour a
// 32-step square root and then a 65-step divide, with the two axes divided side by
// side. Edge points run fewer neighbours. The front end takes a word per
// cycle while the four-entry job queue has room. rst_n clears all control state;
// the line stores are not cleared. A stalled output holds the back end in place.
`timescale 1ns / 1ps
`default_nettype none

module grid_spring_relaxation_step_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // coord_u, coord_v, rest_up_left, rest_up, rest_down_left, rest_down,
    // rest_up_right, rest_down_right, rest_left, rest_right
    input  wire logic [grsr_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation
    input  wire logic [0:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // new_u, new_v
    output logic      [grsr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [grsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [grsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int GW = $clog2(MAX_WIDTH + 1);
    localparam int GH = $clog2(MAX_HEIGHT + 1);
    localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int AW = $clog2(2 * MAX_WIDTH + 3 + grsr_pkg::QUEUE_DEPTH + 2);
    localparam int JW = AW + XW + YW + 1;
    localparam int MW = GW + GH;
    localparam int GW_RST = (grsr_pkg::GRID_SIZE_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                  : grsr_pkg::GRID_SIZE_RST;
    localparam int GH_RST = (grsr_pkg::GRID_SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : grsr_pkg::GRID_SIZE_RST;
    localparam int TOTAL_RST = GW_RST * GH_RST;

    logic [grsr_pkg::DAMP_W-1:0] damping_reg, damping_next;
    logic [grsr_pkg::STEP_W-1:0] step_limit_reg, step_limit_next;
    logic [GW-1:0]               gw_reg, gw_next;
    logic [GH-1:0]               gh_reg, gh_next;
    logic [NW-1:0]               total_reg, total_next;
    logic                        cfg_take, restart;
    int                          size_raw, w_clamp, h_clamp;
    logic [MW-1:0]               prod;
    grsr_pkg::tune_t             tune;

    logic                                          wr_en;
    logic [AW-1:0]                                 wr_addr;
    logic [2*grsr_pkg::COORD_W-1:0]                wr_coord;
    logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] wr_rest;
    logic                                          job_push, job_full, job_valid, job_pop;
    logic [JW-1:0]                                 job_in, job_out;
    logic                                          coord_rd_en, rest_rd_en;
    logic [AW-1:0]                                 coord_rd_addr, rest_rd_addr;
    logic [2*grsr_pkg::COORD_W-1:0]                coord_rd_data;
    logic [grsr_pkg::NB_COUNT*grsr_pkg::REST_W-1:0] rest_rd_data;

    // Register bank; a grid size write restarts the pass.
    always_comb
    begin
        cfg_take        = cfg_valid && cfg_ready;
        size_raw        = int'(cfg_data[grsr_pkg::SIZE_W-1:0]);
        w_clamp         = (size_raw < grsr_pkg::GRID_SIZE_MIN) ? grsr_pkg::GRID_SIZE_MIN :
                          (size_raw > MAX_WIDTH) ? MAX_WIDTH : size_raw;
        h_clamp         = (size_raw < grsr_pkg::GRID_SIZE_MIN) ? grsr_pkg::GRID_SIZE_MIN :
                          (size_raw > MAX_HEIGHT) ? MAX_HEIGHT : size_raw;
        damping_next    = damping_reg;
        step_limit_next = step_limit_reg;
        gw_next         = gw_reg;
        gh_next         = gh_reg;
        restart         = 1'b0;
        if (cfg_take)
        begin
            case (cfg_index)
                grsr_pkg::REG_DAMPING:
                    damping_next = cfg_data[grsr_pkg::DAMP_W-1:0];
                grsr_pkg::REG_STEP_LIMIT:
                    step_limit_next = cfg_data[grsr_pkg::STEP_W-1:0];
                grsr_pkg::REG_GRID_WIDTH:
                begin
                    gw_next = GW'(w_clamp);
                    restart = 1'b1;
                end
                grsr_pkg::REG_GRID_HEIGHT:
                begin
                    gh_next = GH'(h_clamp);
                    restart = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        prod       = MW'(gw_next) * MW'(gh_next);
        total_next = prod[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg    <= grsr_pkg::DAMPING_RST;
            step_limit_reg <= grsr_pkg::STEP_LIMIT_RST;
            gw_reg         <= GW'(GW_RST);
            gh_reg         <= GH'(GH_RST);
            total_reg      <= NW'(TOTAL_RST);
        end
        else
        begin
            damping_reg    <= damping_next;
            step_limit_reg <= step_limit_next;
            gw_reg         <= gw_next;
            gh_reg         <= gh_next;
            total_reg      <= total_next;
        end
    end

    assign cfg_ready       = 1'b1;
    assign tune.damping    = damping_reg;
    assign tune.step_limit = step_limit_reg;

    grsr_front #(
        .GW (GW),
        .NW (NW),
        .XW (XW),
        .YW (YW),
        .AW (AW),
        .JW (JW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_op     (s_tuser[0]),
        .s_coords (s_tdata[2*grsr_pkg::COORD_W-1:0]),
        .s_rests  (s_tdata[grsr_pkg::IN_DATA_W-1:2*grsr_pkg::COORD_W]),
        .restart  (restart),
        .grid_w   (gw_reg),
        .total    (total_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_coord (wr_coord),
        .wr_rest  (wr_rest),
        .job_push (job_push),
        .job_data (job_in),
        .job_full (job_full)
    );

    grsr_fifo #(
        .W (JW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job_out)
    );

    grsr_line_store #(
        .AW (AW)
    ) u_store (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_coord      (wr_coord),
        .wr_rest       (wr_rest),
        .coord_rd_en   (coord_rd_en),
        .coord_rd_addr (coord_rd_addr),
        .coord_rd_data (coord_rd_data),
        .rest_rd_en    (rest_rd_en),
        .rest_rd_addr  (rest_rd_addr),
        .rest_rd_data  (rest_rd_data)
    );

    grsr_back #(
        .GW (GW),
        .GH (GH),
        .XW (XW),
        .YW (YW),
        .AW (AW),
        .JW (JW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_pop       (job_pop),
        .job_data      (job_out),
        .grid_w        (gw_reg),
        .grid_h        (gh_reg),
        .tune          (tune),
        .coord_rd_en   (coord_rd_en),
        .coord_rd_addr (coord_rd_addr),
        .coord_rd_data (coord_rd_data),
        .rest_rd_en    (rest_rd_en),
        .rest_rd_addr  (rest_rd_addr),
        .rest_rd_data  (rest_rd_data),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_data        (m_tdata),
        .m_last        (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for the grid spring relaxation unit: directed grid, then random passes.
// Depends on grsr_pkg and grid_spring_relaxation_step_unit; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;

    localparam int RING       = 2 * 1024 + 3;
    localparam int SETTLE     = 1200;
    localparam int CYCLE_CAP  = 4000000;
    localparam int WORD_GOAL  = 850;

    typedef struct {
        logic [grsr_pkg::COORD_W-1:0] u;
        logic [grsr_pkg::COORD_W-1:0] v;
        bit                           last;
    } relaxed_t;

    typedef struct {
        logic                                 op;
        logic [grsr_pkg::COORD_W-1:0]         u;
        logic [grsr_pkg::COORD_W-1:0]         v;
        logic [7:0][grsr_pkg::REST_W-1:0]     rest;
        bit                                   known;
        logic [grsr_pkg::COORD_W-1:0]         ku;
        logic [grsr_pkg::COORD_W-1:0]         kv;
        bit                                   kl;
    } grid_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [grsr_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [grsr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [grsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [grsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: line stores, counters and its copy of the registers.
    logic [63:0]                  coord_store [RING];
    logic [grsr_pkg::REST_W-1:0]  rest_store [RING][8];
    int                           pw, ph, in_col, in_row, out_pos;
    bit                           in_done;
    logic [grsr_pkg::DAMP_W-1:0]  p_damp;
    logic [grsr_pkg::STEP_W-1:0]  p_step;

    relaxed_t  pending_q[$];
    int        errors = 0;
    int        words_in = 0;
    int        results_seen = 0;
    int        passes = 0;
    int        reg_writes = 0;
    int        cycles = 0;
    int        tx_idle = 0;
    int        rx_idle = 0;

    grid_spring_relaxation_step_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Cycle counter with a hard ceiling on the run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // Fixed-point helpers of the predictor.
    function automatic longint sext32(input logic [31:0] x);
        return longint'($signed(x));
    endfunction

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned magn(input longint x);
        return (x < 0) ? longint'(unsigned'(-x)) : longint'(unsigned'(x));
    endfunction

    function automatic longint unsigned root64(input longint unsigned s);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= r + bitv)
            begin
                s -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint spring_pull(input longint d, input longint f,
                                           input longint unsigned span);
        longint unsigned m;
        longint q;
        m = magn(d) * magn(f);
        q = longint'((m + span / 2) / span);
        return ((d < 0) != (f < 0)) ? -q : q;
    endfunction

    function automatic longint damp_limit(input longint vel);
        longint o, lim;
        o = longint'((magn(vel) * p_damp + (64'd1 << (grsr_pkg::DAMP_BITS - 1)))
                     >> grsr_pkg::DAMP_BITS);
        lim = longint'(p_step);
        if (vel < 0) o = -o;
        if (o > lim) o = lim;
        if (o < -lim) o = -lim;
        return o;
    endfunction

    function automatic int axis_step(input logic [1:0] dir);
        return (dir == grsr_pkg::DIR_MINUS) ? -1 : ((dir == grsr_pkg::DIR_PLUS) ? 1 : 0);
    endfunction

    // Relaxed position of grid point p from the predictor's stores.
    function automatic void relax_point(input int p, output logic [31:0] ru,
                                        output logic [31:0] rv);
        int px, py, nx, ny, i;
        longint cu, cv, du, dv, vu, vv, nu, nv, f;
        logic [63:0] nc;
        longint unsigned span;
        px = p % pw;
        py = p / pw;
        cu = sext32(coord_store[p % RING][31:0]);
        cv = sext32(coord_store[p % RING][63:32]);
        vu = 0;
        vv = 0;
        for (i = 0; i < grsr_pkg::NB_COUNT; i++)
        begin
            nx = px + axis_step(grsr_pkg::NB_DX[i]);
            ny = py + axis_step(grsr_pkg::NB_DY[i]);
            if (nx < 0 || ny < 0 || nx >= pw || ny >= ph) continue;
            nc = coord_store[(ny * pw + nx) % RING];
            du = sat32(sext32(nc[31:0]) - cu);
            dv = sat32(sext32(nc[63:32]) - cv);
            span = root64(magn(du) * magn(du) + magn(dv) * magn(dv));
            // A zero distance gives no direction and hence no pull.
            if (span != 0)
            begin
                f = longint'(span) - longint'({32'd0, rest_store[p % RING][i]});
                vu += spring_pull(du, f, span);
                vv += spring_pull(dv, f, span);
            end
        end
        nu = cu;
        nv = cv;
        if (px > 0 && px < pw - 1) nu = sat32(cu + damp_limit(vu));
        if (py > 0 && py < ph - 1) nv = sat32(cv + damp_limit(vv));
        ru = nu[31:0];
        rv = nv[31:0];
    endfunction

    function automatic void restart_grid();
        in_col = 0;
        in_row = 0;
        in_done = 0;
        out_pos = 0;
    endfunction

    function automatic int clamp_size(input logic [10:0] v);
        if (v < grsr_pkg::GRID_SIZE_MIN) return grsr_pkg::GRID_SIZE_MIN;
        if (v > 1024) return 1024;
        return int'(v);
    endfunction

    // Advances the predictor by one word; returns 1 when a result is due.
    function automatic bit predict_word(input logic op,
                                        input logic [grsr_pkg::IN_DATA_W-1:0] d,
                                        output relaxed_t res);
        int n, slot, i, total;
        total = pw * ph;
        res.last = 0;
        if (op == grsr_pkg::OP_POINT)
        begin
            if (in_done) return 0;
            n = in_row * pw + in_col;
            slot = n % RING;
            coord_store[slot] = d[63:0];
            for (i = 0; i < grsr_pkg::NB_COUNT; i++) rest_store[slot][i] = d[64 + 32 * i +: 32];
            in_col++;
            if (in_col == pw)
            begin
                in_col = 0;
                in_row++;
            end
            if (n + 1 == total) in_done = 1;
            if (n >= pw + 1)
            begin
                relax_point(out_pos, res.u, res.v);
                out_pos++;
                return 1;
            end
            return 0;
        end
        if (!in_done || out_pos >= total) return 0;
        relax_point(out_pos, res.u, res.v);
        out_pos++;
        if (out_pos == total)
        begin
            res.last = 1;
            restart_grid();
        end
        return 1;
    endfunction

    // Sends one word, with random idling before it, and records what it should cause.
    task automatic push_word(input logic op, input logic [grsr_pkg::IN_DATA_W-1:0] d,
                             input bit known, input logic [31:0] ku, input logic [31:0] kv,
                             input bit kl);
        relaxed_t res;
        if ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_in++;
        if (predict_word(op, d, res))
        begin
            if (known)
            begin
                res.u = ku;
                res.v = kv;
                res.last = kl;
            end
            pending_q.push_back(res);
        end
        else if (known)
            report_mismatch("directed row expects a result the grid cannot give");
    endtask

    task automatic write_reg(input logic [grsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [grsr_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == grsr_pkg::REG_DAMPING) p_damp = val[grsr_pkg::DAMP_W-1:0];
        else if (idx == grsr_pkg::REG_STEP_LIMIT) p_step = val[grsr_pkg::STEP_W-1:0];
        else if (idx == grsr_pkg::REG_GRID_WIDTH)
        begin
            pw = clamp_size(val[10:0]);
            restart_grid();
        end
        else if (idx == grsr_pkg::REG_GRID_HEIGHT)
        begin
            ph = clamp_size(val[10:0]);
            restart_grid();
        end
        @(posedge clk);
    endtask

    // Stops sending, waits for every result and lets the back end fall quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One random pass over a small grid; an abandoned pass stops part way.
    task automatic run_pass(input bit abandon);
        logic [grsr_pkg::IN_DATA_W-1:0] d;
        int total, stop, k, j, sc, x, y, i;
        logic [31:0] base_u, base_v, r;
        total = pw * ph;
        stop = abandon ? $urandom_range(1, total - 1) : total;
        sc = 1 << $urandom_range(10, 18);
        base_u = $urandom;
        base_v = $urandom;
        for (k = 0; k < stop; k++)
        begin
            if ($urandom_range(99) < 3)
                push_word(grsr_pkg::OP_FLUSH, grsr_pkg::IN_DATA_W'($urandom), 0, 0, 0, 0);
            x = k % pw;
            y = k / pw;
            if ($urandom_range(9) == 0)
                d[63:0] = {$urandom, $urandom};
            else
            begin
                d[31:0] = base_u + x * sc + $urandom_range(0, sc) - sc / 2;
                d[63:32] = base_v + y * sc + $urandom_range(0, sc) - sc / 2;
            end
            for (i = 0; i < grsr_pkg::NB_COUNT; i++)
            begin
                r = (i == 0 || i == 2 || i == 4 || i == 5) ? (sc * 181) / 128 : sc;
                r = r + $urandom_range(0, sc / 2) - sc / 4;
                if ($urandom_range(9) == 0) r = $urandom;
                d[64 + 32 * i +: 32] = r;
            end
            push_word(grsr_pkg::OP_POINT, d, 0, 0, 0, 0);
        end
        if (!abandon)
        begin
            // Points after the last one of the pass are ignored.
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 2))
                    push_word(grsr_pkg::OP_POINT, {10{$urandom}}, 0, 0, 0, 0);
            for (j = 0; j < pw + 1; j++) push_word(grsr_pkg::OP_FLUSH, '0, 0, 0, 0, 0);
            if ($urandom_range(99) < 20) push_word(grsr_pkg::OP_FLUSH, '0, 0, 0, 0, 0);
        end
        passes++;
    endtask

    function automatic grid_row_t row(input logic op, input logic [31:0] u, input logic [31:0] v,
                                      input logic [7:0][31:0] rest, input bit known,
                                      input logic [31:0] ku, input logic [31:0] kv,
                                      input bit kl);
        grid_row_t t;
        t.op = op;
        t.u = u;
        t.v = v;
        t.rest = rest;
        t.known = known;
        t.ku = ku;
        t.kv = kv;
        t.kl = kl;
        return t;
    endfunction

    // Output side: random back-pressure and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        relaxed_t e;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_q.size() == 0)
                report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
            else
            begin
                e = pending_q.pop_front();
                if (m_tdata[31:0] !== e.u)
                    report_mismatch($sformatf("new_u %h, want %h", m_tdata[31:0], e.u));
                if (m_tdata[63:32] !== e.v)
                    report_mismatch($sformatf("new_v %h, want %h", m_tdata[63:32], e.v));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("frame_last %b, want %b", m_tlast, e.last));
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Main sequence: reset, register setup, directed grid, random passes.
    initial
    begin
        grid_row_t tbl [16];
        logic [7:0][31:0] unit_rest, mixed_rest;
        logic [grsr_pkg::IN_DATA_W-1:0] d;
        int i;
        bit abandon;

        p_damp = grsr_pkg::DAMPING_RST;
        p_step = grsr_pkg::STEP_LIMIT_RST;
        pw = grsr_pkg::GRID_SIZE_RST;
        ph = grsr_pkg::GRID_SIZE_RST;
        restart_grid();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size writes saturate at both ends; unknown indexes change nothing.
        write_reg(grsr_pkg::REG_GRID_WIDTH, 32'h0000_07FF);
        write_reg(grsr_pkg::REG_GRID_HEIGHT, 32'h0000_0000);
        write_reg(grsr_pkg::REG_GRID_WIDTH, 32'h0000_0001);
        write_reg(grsr_pkg::REG_DAMPING, 32'h0000_FFFF);
        write_reg(grsr_pkg::REG_STEP_LIMIT, 32'hFFFF_FFFF);
        write_reg(grsr_pkg::CFG_IDX_W'(4), $urandom);
        write_reg(grsr_pkg::CFG_IDX_W'(255), $urandom);

        // Directed 3x3 grid at the coordinate extremes; corners must not move.
        unit_rest = {8{32'h0001_0000}};
        mixed_rest = {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        tbl[0]  = row(grsr_pkg::OP_FLUSH, 0, 0, unit_rest, 0, 0, 0, 0);
        tbl[1]  = row(grsr_pkg::OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, unit_rest, 0, 0, 0, 0);
        tbl[2]  = row(grsr_pkg::OP_POINT, 32'h0000_0000, 32'h0000_0000, unit_rest, 0, 0, 0, 0);
        tbl[3]  = row(grsr_pkg::OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, unit_rest, 0, 0, 0, 0);
        tbl[4]  = row(grsr_pkg::OP_POINT, 32'h0001_0000, 32'hFFFF_0000, {8{32'hFFFF_FFFF}},
                      0, 0, 0, 0);
        tbl[5]  = row(grsr_pkg::OP_POINT, 32'h0000_0000, 32'h0000_0000, mixed_rest, 1,
                      32'h7FFF_FFFF, 32'h8000_0000, 0);
        tbl[6]  = row(grsr_pkg::OP_POINT, 32'hFFFF_8000, 32'h0001_8000, {8{32'h0}}, 0, 0, 0, 0);
        tbl[7]  = row(grsr_pkg::OP_POINT, 32'h0000_0001, 32'hFFFF_FFFF, unit_rest, 1,
                      32'h8000_0000, 32'h7FFF_FFFF, 0);
        tbl[8]  = row(grsr_pkg::OP_POINT, 32'h0000_0000, 32'h0000_0000, unit_rest, 0, 0, 0, 0);
        tbl[9]  = row(grsr_pkg::OP_POINT, 32'hFFFF_FFFF, 32'h0000_0001, unit_rest, 0, 0, 0, 0);
        tbl[10] = row(grsr_pkg::OP_POINT, 32'h1234_5678, 32'h9ABC_DEF0, {8{32'h5A5A_A5A5}},
                      0, 0, 0, 0);
        tbl[11] = row(grsr_pkg::OP_FLUSH, 0, 0, unit_rest, 0, 0, 0, 0);
        tbl[12] = row(grsr_pkg::OP_FLUSH, 0, 0, unit_rest, 1, 32'h0000_0001, 32'hFFFF_FFFF, 0);
        tbl[13] = row(grsr_pkg::OP_FLUSH, 0, 0, unit_rest, 0, 0, 0, 0);
        tbl[14] = row(grsr_pkg::OP_FLUSH, 0, 0, unit_rest, 1, 32'hFFFF_FFFF, 32'h0000_0001, 1);
        tbl[15] = row(grsr_pkg::OP_FLUSH, 0, 0, unit_rest, 0, 0, 0, 0);
        tx_idle = 29;
        rx_idle = 56;
        for (i = 0; i < 16; i++)
        begin
            d = {tbl[i].rest, tbl[i].v, tbl[i].u};
            push_word(tbl[i].op, d, tbl[i].known, tbl[i].ku, tbl[i].kv, tbl[i].kl);
        end
        wait_idle();

        // Random passes, moving through the idling phases as the word count grows.
        abandon = 0;
        while (words_in < WORD_GOAL)
        begin
            if (words_in < 300)
            begin
                tx_idle = 29;
                rx_idle = 56;
            end
            else if (words_in < 600)
            begin
                tx_idle = 56;
                rx_idle = 29;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case ($urandom_range(5))
                0: write_reg(grsr_pkg::REG_DAMPING, 32'h0);
                1: write_reg(grsr_pkg::REG_DAMPING, 32'hFFFF);
                default: write_reg(grsr_pkg::REG_DAMPING, $urandom);
            endcase
            case ($urandom_range(5))
                0: write_reg(grsr_pkg::REG_STEP_LIMIT, 32'h0);
                1: write_reg(grsr_pkg::REG_STEP_LIMIT, 32'h7FFF_FFFF);
                default: write_reg(grsr_pkg::REG_STEP_LIMIT, $urandom_range(0, 32'h0004_0000));
            endcase
            if (abandon || $urandom_range(2) == 0)
            begin
                write_reg(grsr_pkg::REG_GRID_WIDTH, $urandom_range(0, 6));
                write_reg(grsr_pkg::REG_GRID_HEIGHT, $urandom_range(0, 5));
            end
            abandon = ($urandom_range(9) == 0);
            run_pass(abandon);
            wait_idle();
        end

        while (pending_q.size() != 0)
        begin
            relaxed_t e;
            e = pending_q.pop_front();
            report_mismatch($sformatf("result never arrived: %h %h", e.v, e.u));
        end
        $display("Sent %0d words over %0d passes with %0d register writes,", words_in,
                 passes, reg_writes);
        $display("and checked %0d relaxed points on output.", results_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
